>>> sv/mix_hash_128_and_checksum_macros.svh
// Assertion macros for the mix_hash_128_and_checksum RTL.
// No dependencies. Expects clk_i and rst_ni in the scope of each use.
`ifndef MIX_HASH_128_AND_CHECKSUM_MACROS_SVH
`define MIX_HASH_128_AND_CHECKSUM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define MH128_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define MH128_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MH128_ASSERT_IMP(lbl, ante, cons, msg)
`define MH128_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/mh128_pkg.sv
// Shared types, constants and helper functions of the mix_hash_128_and_checksum block.
// No dependencies.
package mh128_pkg;

  // Finalizer multipliers, lane start values and checksum seed
  localparam logic [63:0] MIX_K1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_K2     = 64'h94d049bb133111eb;
  localparam logic [63:0] INIT_A     = 64'h243f6a8885a308d3;
  localparam logic [63:0] INIT_B     = 64'h13198a2e03707344;
  localparam logic [63:0] CHECK_SEED = 64'ha5a5a5a5d3c1b2e7;

  // Stream widths
  localparam int unsigned S_TDATA_W = 232;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 128;

  // Block and word sizes in bytes
  localparam logic [4:0] BLOCK_BYTES = 5'd16;
  localparam logic [4:0] WORD_BYTES  = 5'd8;

  // Request to the finalizer unit
  typedef struct packed {
    logic        start;
    logic [63:0] arg;
  } fmix_req_t;

  // Response from the finalizer unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } fmix_rsp_t;

  // Rotate left by a constant amount in 1..63
  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Zero all bytes at or above index n
  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [4:0] n);
    logic [63:0] r;
    r = w;
    for (int i = 0; i < 8; i++) begin
      if (5'(i) >= n) r[8*i +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

>>> sv/mix_hash_128_and_checksum.sv
// Top level of the 128-bit hash / 64-bit checksum block: stream ports, block
// sequencer and lane state. Uses mh128_pkg and mh128_fmix.
`include "mix_hash_128_and_checksum_macros.svh"

// Takes one 16-byte block per input item and returns one result item after a
// block marked last. All lane arithmetic goes through one finalizer unit built
// on a single 32x32 multiplier; each finalizer pass runs two 64-bit multiplies
// of three partial products each, plus load and handoff.
// A block that is neither first nor a short last block takes two passes.
// A first block adds two passes. A last block adds four passes and the push
// step, five passes in checksum mode. The input is not ready while a block is in
// work; a finished result waits in the output register and the next item is
// taken meanwhile.
module mix_hash_128_and_checksum #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [63:0] word_lo, [127:64] word_hi, [132:128] valid_bytes,
  // [164:133] total_bytes, [228:165] seed_value, [231:229] zero
  input  logic [mh128_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] operation, [1] first
  input  logic [mh128_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [63:0] digest_lo, [127:64] digest_hi
  output logic [mh128_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] length_error
  output logic                              m_axis_tuser_o
);
  import mh128_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_A,
    S_INIT_B,
    S_BLK_A,
    S_BLK_B,
    S_FIN_A,
    S_FIN_B,
    S_H0,
    S_H1,
    S_CHK,
    S_PUSH
  } state_e;

  state_e                  state_q;
  logic                    kick_q;
  logic                    kick_d;
  logic [63:0]             lane_a_q;
  logic [63:0]             lane_b_q;
  logic [LENGTH_WIDTH-1:0] bytes_seen_q;
  logic [LENGTH_WIDTH-1:0] length_latched_q;
  logic                    mode_latched_q;
  logic                    error_seen_q;
  logic [63:0]             seed_q;
  logic [63:0]             x_q;
  logic [63:0]             y_q;
  logic [4:0]              v_q;
  logic                    last_q;
  logic                    full_q;
  logic                    res_err_q;
  logic [63:0]             res_lo_q;
  logic [63:0]             res_hi_q;
  logic                    m_valid_q;
  logic                    m_valid_d;
  logic [M_TDATA_W-1:0]    m_data_q;
  logic                    m_err_q;

  // Input fields
  logic        in_op;
  logic        in_first;
  logic        in_last;
  logic [63:0] in_word_lo;
  logic [63:0] in_word_hi;
  logic [4:0]  in_valid_bytes;
  logic [31:0] in_total_bytes;
  logic [63:0] in_seed;

  assign in_op          = s_axis_tuser_i[0];
  assign in_first       = s_axis_tuser_i[1];
  assign in_last        = s_axis_tlast_i;
  assign in_word_lo     = s_axis_tdata_i[63:0];
  assign in_word_hi     = s_axis_tdata_i[127:64];
  assign in_valid_bytes = s_axis_tdata_i[132:128];
  assign in_total_bytes = s_axis_tdata_i[164:133];
  assign in_seed        = s_axis_tdata_i[228:165];

  logic s_accept;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Accept-time bookkeeping: clamp, mask, count and error flags
  logic                    bad_count;
  logic [4:0]              v_clamp;
  logic                    full_in;
  logic [63:0]             x_in;
  logic [63:0]             y_in;
  logic [63:0]             len_mask;
  logic [63:0]             len_full;
  logic [LENGTH_WIDTH-1:0] length_latched_d;
  logic [LENGTH_WIDTH-1:0] bytes_base;
  logic [LENGTH_WIDTH:0]   bytes_sum;
  logic [LENGTH_WIDTH-1:0] bytes_seen_d;
  logic                    error_seen_d;
  logic                    res_err_d;
  logic [63:0]             seed_d;

  assign bad_count = (in_valid_bytes > BLOCK_BYTES);
  assign v_clamp   = bad_count ? BLOCK_BYTES : in_valid_bytes;
  assign full_in   = (v_clamp == BLOCK_BYTES);
  assign x_in      = keep_bytes(in_word_lo, v_clamp);
  assign y_in      = (v_clamp > WORD_BYTES) ? keep_bytes(in_word_hi, v_clamp - WORD_BYTES)
                                            : 64'd0;

  assign len_mask         = {64{1'b1}} >> (64 - LENGTH_WIDTH);
  assign len_full         = {32'b0, in_total_bytes} & len_mask;
  assign length_latched_d = in_first ? len_full[LENGTH_WIDTH-1:0] : length_latched_q;
  assign seed_d           = in_seed ^ (in_op ? CHECK_SEED : 64'd0);

  assign bytes_base   = in_first ? '0 : bytes_seen_q;
  assign bytes_sum    = {1'b0, bytes_base} + {{(LENGTH_WIDTH-4){1'b0}}, v_clamp};
  assign bytes_seen_d = bytes_sum[LENGTH_WIDTH] ? {LENGTH_WIDTH{1'b1}}
                                                : bytes_sum[LENGTH_WIDTH-1:0];
  assign error_seen_d = (in_first ? 1'b0 : error_seen_q) | bad_count |
                        (!in_last && !full_in) | bytes_sum[LENGTH_WIDTH];
  assign res_err_d    = error_seen_d || (bytes_seen_d != length_latched_d);

  // Finalizer operand per step
  logic [63:0] len_ext;
  logic [63:0] rem;
  logic [63:0] t0;
  logic [63:0] t1;
  fmix_req_t   freq;
  fmix_rsp_t   frsp;

  assign len_ext = 64'(length_latched_q);
  assign rem     = full_q ? 64'd0 : {59'd0, v_q};
  assign t0      = full_q ? 64'd0 : x_q;
  assign t1      = full_q ? 64'd0 : y_q;

  always_comb begin
    freq.start = kick_q;
    unique case (state_q)
      S_INIT_A: freq.arg = INIT_A ^ seed_q ^ len_ext;
      S_INIT_B: freq.arg = INIT_B + seed_q + (len_ext << 1);
      S_BLK_A:  freq.arg = lane_a_q ^ x_q ^ rotl64(y_q, 17);
      S_BLK_B:  freq.arg = lane_b_q ^ y_q ^ rotl64(x_q, 31);
      S_FIN_A:  freq.arg = lane_a_q ^ t0 ^ rem;
      S_FIN_B:  freq.arg = lane_b_q ^ t1 ^ rotl64(rem, 13);
      S_H0:     freq.arg = lane_a_q;
      S_H1:     freq.arg = lane_b_q;
      S_CHK:    freq.arg = res_lo_q ^ rotl64(res_hi_q, 29) ^ len_ext;
      default:  freq.arg = 64'd0;
    endcase
  end

  // Start of the next finalizer pass
  always_comb begin
    unique case (state_q) inside
      S_IDLE:                                           kick_d = s_accept;
      S_INIT_A, S_INIT_B, S_BLK_A, S_FIN_A, S_FIN_B, S_H0: kick_d = frsp.done;
      S_BLK_B:                                          kick_d = frsp.done && last_q;
      S_H1:                                             kick_d = frsp.done && mode_latched_q;
      default:                                          kick_d = 1'b0;
    endcase
  end

  // Output valid: set by the push step, cleared when the item is taken
  assign m_valid_d = (state_q == S_PUSH) || (m_valid_q && !m_axis_tready_i);

  mh128_fmix u_fmix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (freq),
    .rsp_o  (frsp)
  );

  // Cross mix of the lanes after the tail pass
  logic [63:0] fin_a;
  logic [63:0] fin_b;
  assign fin_a = lane_a_q ^ rotl64(frsp.res, 23);
  assign fin_b = frsp.res ^ rotl64(fin_a, 41);

  // Sequencer, lane state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      kick_q           <= 1'b0;
      lane_a_q         <= '0;
      lane_b_q         <= '0;
      bytes_seen_q     <= '0;
      length_latched_q <= '0;
      mode_latched_q   <= 1'b0;
      error_seen_q     <= 1'b0;
      seed_q           <= '0;
      x_q              <= '0;
      y_q              <= '0;
      v_q              <= '0;
      last_q           <= 1'b0;
      full_q           <= 1'b0;
      res_err_q        <= 1'b0;
      res_lo_q         <= '0;
      res_hi_q         <= '0;
      m_valid_q        <= 1'b0;
      m_data_q         <= '0;
      m_err_q          <= 1'b0;
    end else begin
      kick_q    <= kick_d;
      m_valid_q <= m_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            bytes_seen_q     <= bytes_seen_d;
            length_latched_q <= length_latched_d;
            error_seen_q     <= error_seen_d;
            res_err_q        <= res_err_d;
            x_q              <= x_in;
            y_q              <= y_in;
            v_q              <= v_clamp;
            last_q           <= in_last;
            full_q           <= full_in;
            if (in_first) begin
              seed_q         <= seed_d;
              mode_latched_q <= in_op;
            end
            if (in_first) state_q <= S_INIT_A;
            else if (!in_last || full_in) state_q <= S_BLK_A;
            else state_q <= S_FIN_A;
          end
        end
        S_INIT_A: begin
          if (frsp.done) begin
            lane_a_q <= frsp.res;
            state_q  <= S_INIT_B;
          end
        end
        S_INIT_B: begin
          if (frsp.done) begin
            lane_b_q <= frsp.res;
            state_q  <= (!last_q || full_q) ? S_BLK_A : S_FIN_A;
          end
        end
        S_BLK_A: begin
          if (frsp.done) begin
            lane_a_q <= frsp.res;
            state_q  <= S_BLK_B;
          end
        end
        S_BLK_B: begin
          if (frsp.done) begin
            lane_b_q <= frsp.res;
            if (last_q) begin
              state_q <= S_FIN_A;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_FIN_A: begin
          if (frsp.done) begin
            lane_a_q <= frsp.res;
            state_q  <= S_FIN_B;
          end
        end
        S_FIN_B: begin
          if (frsp.done) begin
            lane_a_q <= fin_a;
            lane_b_q <= fin_b;
            state_q  <= S_H0;
          end
        end
        S_H0: begin
          if (frsp.done) begin
            res_lo_q <= frsp.res;
            state_q  <= S_H1;
          end
        end
        S_H1: begin
          if (frsp.done) begin
            res_hi_q <= frsp.res;
            if (mode_latched_q) begin
              state_q <= S_CHK;
            end else begin
              state_q <= S_PUSH;
            end
          end
        end
        S_CHK: begin
          if (frsp.done) begin
            res_lo_q <= frsp.res;
            res_hi_q <= 64'd0;
            state_q  <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= {res_hi_q, res_lo_q};
            m_err_q   <= res_err_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;

  `MH128_ASSERT_NXT(a_accept_busy, s_accept, !s_axis_tready_o && kick_q,
                    "block accepted without starting work")
  `MH128_ASSERT_IMP(a_done_in_step, frsp.done, state_q != S_IDLE && state_q != S_PUSH,
                    "finalizer result with no step waiting")
  `MH128_ASSERT_IMP(a_kick_idle_unit, kick_q, !frsp.busy, "finalizer kicked while busy")
  `MH128_ASSERT_IMP(a_result_from_push, $rose(m_axis_tvalid_o), $past(state_q == S_PUSH),
                    "result item raised outside the push step")

endmodule

>>> sv/mh128_fmix.sv
// Iterative splitmix64 finalizer: two 64-bit multiplies, each built from
// three 32x32 partial products on one shared multiplier. Uses mh128_pkg.
`include "mix_hash_128_and_checksum_macros.svh"

module mh128_fmix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mh128_pkg::fmix_req_t  req_i,
  output mh128_pkg::fmix_rsp_t  rsp_o
);
  import mh128_pkg::*;

  typedef enum logic {
    F_IDLE,
    F_RUN
  } fstate_e;

  fstate_e     state_q;
  logic [1:0]  phase_q;
  logic        second_q;
  logic [63:0] v_q;
  logic [63:0] acc_q;
  logic [63:0] res_q;
  logic        done_q;

  logic [63:0] k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] prod_sh;
  logic [63:0] p_sum;

  // Operand select for the shared 32x32 multiplier:
  // phase 0 lo*lo, phase 1 lo*hi, phase 2 hi*lo
  assign k       = second_q ? MIX_K2 : MIX_K1;
  assign mul_a   = (phase_q == 2'd2) ? v_q[63:32] : v_q[31:0];
  assign mul_b   = (phase_q == 2'd1) ? k[63:32] : k[31:0];
  assign prod    = {32'b0, mul_a} * {32'b0, mul_b};
  assign prod_sh = {prod[31:0], 32'b0};
  assign p_sum   = acc_q + prod_sh;

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      phase_q  <= 2'd0;
      second_q <= 1'b0;
      v_q      <= '0;
      acc_q    <= '0;
      res_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      // done is registered from the last phase of the second multiply, together with the result
      done_q <= (state_q == F_RUN) && (phase_q >= 2'd2) && second_q;
      unique case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            v_q      <= req_i.arg ^ (req_i.arg >> 30);
            phase_q  <= 2'd0;
            second_q <= 1'b0;
            state_q  <= F_RUN;
          end
        end
        F_RUN: begin
          unique case (phase_q)
            2'd0: begin
              acc_q   <= prod;
              phase_q <= 2'd1;
            end
            2'd1: begin
              acc_q   <= p_sum;
              phase_q <= 2'd2;
            end
            default: begin
              phase_q <= 2'd0;
              if (!second_q) begin
                v_q      <= p_sum ^ (p_sum >> 27);
                second_q <= 1'b1;
              end else begin
                res_q   <= p_sum ^ (p_sum >> 31);
                state_q <= F_IDLE;
              end
            end
          endcase
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q == F_RUN);
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  `MH128_ASSERT_IMP(a_start_idle, req_i.start, state_q == F_IDLE, "fmix started while busy")
  `MH128_ASSERT_NXT(a_done_pulse, done_q, !done_q, "fmix done held longer than a cycle")
  `MH128_ASSERT_NXT(a_start_no_done, req_i.start, !done_q && state_q == F_RUN,
                    "fmix finished too early")

endmodule

>>> sim/mix_hash_128_and_checksum_tb.sv
// Self-checking testbench of mix_hash_128_and_checksum: directed and random message blocks,
// checked against an in-bench lane predictor. Depends on mh128_pkg and the block's RTL.
module mix_hash_128_and_checksum_tb;
  import mh128_pkg::*;

  // Operation codes carried in tuser[0]
  localparam logic OP_HASH     = 1'b0;
  localparam logic OP_CHECKSUM = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam longint unsigned TIMEOUT_CYCLES = 800000;

  // One 16-byte block as seen by the sender
  typedef struct {
    logic        op;
    logic        first;
    logic        last;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  vb;
    logic [31:0] total;
    logic [63:0] seed;
    bit          drain;
  } block_t;

  // One digest as returned by the block
  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        err;
  } digest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  mix_hash_128_and_checksum dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  block_t      pending_blocks[$];
  digest_t     expected_digests[$];
  block_t      block_on_bus;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned digests_predicted = 0;
  int unsigned digests_seen = 0;
  int unsigned checksum_seen = 0;
  int unsigned error_flags_seen = 0;
  int unsigned fail_cnt = 0;

  // Predictor state
  logic [63:0] lane_a = '0;
  logic [63:0] lane_b = '0;
  logic [31:0] bytes_seen = '0;
  logic [31:0] length_latched = '0;
  logic        mode_latched = OP_HASH;
  logic        error_seen = 1'b0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned n);
    logic [127:0] d;
    d = {v, v} << n;
    return d[127:64];
  endfunction

  // splitmix64 finalizer
  function automatic logic [63:0] fin64(input logic [63:0] v);
    logic [63:0] t;
    t = v ^ (v >> 30);
    t = t * MIX_K1;
    t = t ^ (t >> 27);
    t = t * MIX_K2;
    return t ^ (t >> 31);
  endfunction

  // Clear every byte at or above index n
  function automatic logic [63:0] mask_bytes(input logic [63:0] w, input logic [4:0] n);
    if (n >= 5'd8) return w;
    return w & ~({64{1'b1}} << (8 * n));
  endfunction

  // Advance the lanes by one accepted block; queue a digest on a last block
  task automatic absorb_block(input block_t b);
    logic [4:0]  v;
    bit          bad;
    logic [63:0] len, s, x, y, rem, t0, t1, h0, h1;
    logic [32:0] nb;
    digest_t     d;
    v = b.vb;
    bad = 0;
    if (v > BLOCK_BYTES) begin
      v = BLOCK_BYTES;
      bad = 1;
    end
    if (b.first) begin
      len = {32'h0, b.total};
      s = b.seed ^ ((b.op == OP_CHECKSUM) ? CHECK_SEED : 64'h0);
      lane_a = fin64(INIT_A ^ s ^ len);
      lane_b = fin64(INIT_B + s + (len << 1));
      bytes_seen = '0;
      length_latched = b.total;
      mode_latched = b.op;
      error_seen = 1'b0;
    end
    if (bad) error_seen = 1'b1;
    x = mask_bytes(b.lo, v);
    y = (v > WORD_BYTES) ? mask_bytes(b.hi, v - WORD_BYTES) : 64'h0;
    if (!b.last && v != BLOCK_BYTES) error_seen = 1'b1;
    if (!b.last || v == BLOCK_BYTES) begin
      lane_a = fin64(lane_a ^ x ^ rot_left(y, 17));
      lane_b = fin64(lane_b ^ y ^ rot_left(x, 31));
    end
    // byte counter saturates on overflow
    nb = {1'b0, bytes_seen} + {28'h0, v};
    if (nb[32]) begin
      bytes_seen = '1;
      error_seen = 1'b1;
    end else begin
      bytes_seen = nb[31:0];
    end
    if (b.last) begin
      // a full last block finalizes with an empty tail
      rem = (v == BLOCK_BYTES) ? 64'h0 : {59'h0, v};
      t0 = (v == BLOCK_BYTES) ? 64'h0 : x;
      t1 = (v == BLOCK_BYTES) ? 64'h0 : y;
      lane_a = fin64(lane_a ^ t0 ^ rem);
      lane_b = fin64(lane_b ^ t1 ^ rot_left(rem, 13));
      lane_a = lane_a ^ rot_left(lane_b, 23);
      lane_b = lane_b ^ rot_left(lane_a, 41);
      h0 = fin64(lane_a);
      h1 = fin64(lane_b);
      if (mode_latched == OP_CHECKSUM) begin
        d.lo = fin64(h0 ^ rot_left(h1, 29) ^ {32'h0, length_latched});
        d.hi = 64'h0;
      end else begin
        d.lo = h0;
        d.hi = h1;
      end
      d.err = error_seen || (bytes_seen != length_latched);
      expected_digests = {expected_digests, d};
      digests_predicted++;
    end
  endtask

  task automatic push_block(input logic op, input logic first, input logic last,
                            input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] vb, input logic [31:0] total,
                            input logic [63:0] seed, input bit drain);
    block_t b;
    b.op = op;
    b.first = first;
    b.last = last;
    b.lo = lo;
    b.hi = hi;
    b.vb = vb;
    b.total = total;
    b.seed = seed;
    b.drain = drain;
    pending_blocks = {pending_blocks, b};
    items_queued++;
  endtask

  // Message of nbytes bytes in full blocks plus a tail; total may disagree on purpose
  task automatic push_message(input logic op, input int unsigned nbytes,
                              input logic [31:0] total, input bit drain);
    int unsigned nblk;
    int unsigned tail;
    nblk = (nbytes == 0) ? 1 : (nbytes + 15) / 16;
    tail = nbytes - 16 * (nblk - 1);
    for (int unsigned i = 0; i < nblk; i++) begin
      if (i == 0)
        push_block(op, 1'b1, nblk == 1, rand64(), rand64(),
                   (nblk == 1) ? 5'(tail) : BLOCK_BYTES, total, rand64(), drain);
      else
        // fields read only on the first block carry random junk here
        push_block(1'($urandom), 1'b0, i == nblk - 1, rand64(), rand64(),
                   (i == nblk - 1) ? 5'(tail) : BLOCK_BYTES, $urandom, rand64(), 1'b0);
    end
  endtask

  // Sender: one item per handshake, random gaps, optional hold-off until all digests are back
  bit          calm_tx = 0;
  int unsigned tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      s_tlast <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_block(block_on_bus);
        items_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_blocks.size() != 0 &&
                     !(pending_blocks[0].drain && digests_predicted != digests_seen)) begin
          block_on_bus = pending_blocks.pop_front();
          s_tdata <= {3'b000, block_on_bus.seed, block_on_bus.total, block_on_bus.vb,
                      block_on_bus.hi, block_on_bus.lo};
          s_tuser <= {block_on_bus.first, block_on_bus.op};
          s_tlast <= block_on_bus.last;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 15) == 0) calm_tx = !calm_tx;
          tx_gap <= calm_tx ? 0 : $urandom_range(0, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each digest with the oldest prediction, random stalls
  bit          calm_rx = 0;
  int unsigned rx_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    digest_t     want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      digests_seen <= digests_seen + 1;
      if (m_tdata[63:0] != 64'h0 && m_tdata[127:64] == 64'h0) checksum_seen++;
      if (m_tuser) error_flags_seen++;
      if (expected_digests.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected digest: lo=%h hi=%h err=%b", m_tdata[63:0], m_tdata[127:64],
                   m_tuser);
      end else begin
        want = expected_digests.pop_front();
        if (m_tdata[63:0] !== want.lo || m_tdata[127:64] !== want.hi || m_tuser !== want.err)
        begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("digest mismatch: lo exp=%h got=%h, hi exp=%h got=%h, err exp=%b got=%b",
                     want.lo, m_tdata[63:0], want.hi, m_tdata[127:64], want.err, m_tuser);
        end
      end
      if ($urandom_range(0, 15) == 0) calm_rx = !calm_rx;
      n = calm_rx ? 0 : $urandom_range(0, 4);
      rx_stall <= n;
      m_tready <= (n == 0);
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= (rx_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned r, nbytes, nblk;
    logic        op;
    logic [31:0] total;

    // Block with no first marker straight after reset: works on zero lanes
    push_block(OP_HASH, 1'b0, 1'b0, '1, '1, BLOCK_BYTES, '1, '1, 1'b0);
    push_block(OP_HASH, 1'b0, 1'b1, rand64(), rand64(), 5'd5, '0, '0, 1'b0);
    // Empty messages in both modes
    push_block(OP_HASH, 1'b1, 1'b1, '1, '1, 5'd0, 32'd0, 64'h0, 1'b0);
    push_block(OP_CHECKSUM, 1'b1, 1'b1, '1, '1, 5'd0, 32'd0, '1, 1'b0);
    // Single full last block, all ones
    push_block(OP_HASH, 1'b1, 1'b1, '1, '1, BLOCK_BYTES, 32'd16, '1, 1'b0);
    // Two full blocks, checksum
    push_block(OP_CHECKSUM, 1'b1, 1'b0, '0, '0, BLOCK_BYTES, 32'd32, '0, 1'b0);
    push_block(OP_CHECKSUM, 1'b0, 1'b1, '1, '1, BLOCK_BYTES, 32'd0, '1, 1'b0);
    // Full block then a four-byte tail
    push_block(OP_HASH, 1'b1, 1'b0, rand64(), rand64(), BLOCK_BYTES, 32'd20, rand64(), 1'b0);
    push_block(OP_HASH, 1'b0, 1'b1, '1, '1, 5'd4, 32'd0, rand64(), 1'b0);
    // Oversized valid count, largest declared length
    push_block(OP_CHECKSUM, 1'b1, 1'b1, '1, '1, 5'd31, '1, rand64(), 1'b0);
    // Short block that is not last, then a nine-byte tail
    push_block(OP_HASH, 1'b1, 1'b0, '1, '1, 5'd7, 32'd16, rand64(), 1'b0);
    push_block(OP_HASH, 1'b0, 1'b1, '1, '1, 5'd9, 32'd0, rand64(), 1'b0);
    // First block inside an open message restarts it
    push_block(OP_HASH, 1'b1, 1'b0, rand64(), rand64(), BLOCK_BYTES, 32'd48, rand64(), 1'b0);
    push_block(OP_CHECKSUM, 1'b1, 1'b0, rand64(), rand64(), BLOCK_BYTES, 32'd17, rand64(), 1'b0);
    push_block(OP_HASH, 1'b0, 1'b1, '1, '1, 5'd1, 32'd0, rand64(), 1'b0);
    // Declared length disagrees with the bytes given; hold off until drained first
    push_block(OP_HASH, 1'b1, 1'b1, '1, '1, 5'd8, 32'd9, rand64(), 1'b1);
    push_block(OP_HASH, 1'b1, 1'b1, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef,
               5'd15, 32'd15, 64'h8000_0000_0000_0000, 1'b0);

    // Random part: mostly well-formed messages, some broken ones and noise
    while (items_queued < RANDOM_ITEMS + 17) begin
      r = $urandom_range(0, 19);
      op = ($urandom_range(0, 1) == 0) ? OP_HASH : OP_CHECKSUM;
      nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160) : $urandom_range(0, 48);
      if (r < 13) begin
        push_message(op, nbytes, 32'(nbytes), $urandom_range(0, 60) == 0);
      end else if (r < 15) begin
        // wrong declared length
        total = ($urandom_range(0, 3) == 0) ? $urandom : 32'(nbytes + $urandom_range(1, 20));
        if (total == 32'(nbytes)) total = total + 1;
        push_message(op, nbytes, total, 1'b0);
      end else if (r < 17) begin
        // broken message with random valid counts
        nblk = $urandom_range(1, 4);
        total = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 64);
        for (int unsigned i = 0; i < nblk; i++)
          push_block(i == 0 ? op : 1'($urandom), i == 0, i == nblk - 1, rand64(), rand64(),
                     5'($urandom_range(0, 31)), i == 0 ? total : $urandom, rand64(), 1'b0);
      end else begin
        // noise: every field random
        push_block(1'($urandom), 1'($urandom), 1'($urandom), rand64(), rand64(),
                   5'($urandom_range(0, 31)), $urandom, rand64(), 1'b0);
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_blocks.size() != 0 || s_tvalid) @(negedge clk_i);
    while (digests_seen != digests_predicted) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    fail_cnt += expected_digests.size();

    $display("run covered %0d blocks and %0d digests (%0d checksum, %0d flagged bad length)",
             items_sent, digests_seen, checksum_seen, error_flags_seen);
    $display("failures counted: %0d", fail_cnt);
    if (fail_cnt == 0) begin
      $display("mix_hash_128_and_checksum regression: pass");
    end else begin
      $display("mix_hash_128_and_checksum regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("mix_hash_128_and_checksum regression: fail");
    $finish;
  end

endmodule
